// File: rtl/core/tes_pkg.sv
// Shared types, codes and write-decode tables for the tick event sequencer.
`default_nettype none
package tes_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_PAUSE   = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_FETCH = 3'd1,
    STEP_WAIT  = 3'd2,
    STEP_EMIT  = 3'd3,
    STEP_FLUSH = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    COND_TICK_GO    = 3'd0,
    COND_RUN_OUT    = 3'd1,
    COND_LATE       = 3'd2,
    COND_EMIT_DONE  = 3'd3,
    COND_FLUSH_DONE = 3'd4
  } cond_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic clear_k;
    logic emit;
    logic flush;
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
    act_t  act;
  } cword_t;

  typedef struct packed {
    logic tick_go;
    logic run_out;
    logic late;
    logic emit_done;
    logic flush_done;
  } status_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
  } wr_t;

  localparam logic [7:0] D_VOL_FULL = 8'hF0;
  localparam logic [7:0] D_DUTY     = 8'h80;
  localparam logic [7:0] D_WAVE_LEN = 8'hF1;
  localparam logic [7:0] D_WAVE_LVL = 8'h6F;
  localparam logic [7:0] D_NOISE    = 8'h20;
  localparam logic [7:0] D_ZERO     = 8'h00;
  localparam logic [7:0] D_TRIG     = 8'h80;
  localparam logic [2:0] HI_MASK    = 3'h7;

  localparam logic [1:0] CH_PULSE1 = 2'd0;
  localparam logic [1:0] CH_PULSE2 = 2'd1;
  localparam logic [1:0] CH_WAVE   = 2'd2;
  localparam logic [1:0] CH_NOISE  = 2'd3;

  function automatic cword_t ucode(input step_t s);
    cword_t w;
    w = '{cond: COND_TICK_GO, tgt_t: STEP_IDLE, tgt_f: STEP_IDLE, act: '0};
    case (s)
      STEP_IDLE: begin
        w.cond = COND_TICK_GO;  w.tgt_t = STEP_FETCH; w.tgt_f = STEP_IDLE;
        w.act.accept = 1'b1;
      end
      STEP_FETCH: begin
        w.cond = COND_RUN_OUT;  w.tgt_t = STEP_FLUSH; w.tgt_f = STEP_WAIT;
        w.act.read = 1'b1;
      end
      STEP_WAIT: begin
        w.cond = COND_LATE;     w.tgt_t = STEP_FLUSH; w.tgt_f = STEP_EMIT;
        w.act.clear_k = 1'b1;
      end
      STEP_EMIT: begin
        w.cond = COND_EMIT_DONE; w.tgt_t = STEP_FETCH; w.tgt_f = STEP_EMIT;
        w.act.emit = 1'b1;
      end
      STEP_FLUSH: begin
        w.cond = COND_FLUSH_DONE; w.tgt_t = STEP_IDLE; w.tgt_f = STEP_FLUSH;
        w.act.flush = 1'b1;
      end
      default: begin
        w.cond = COND_FLUSH_DONE; w.tgt_t = STEP_IDLE; w.tgt_f = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [2:0] wr_count(input logic [1:0] ch, input logic on);
    logic [2:0] n;
    if (on) n = 3'd4;
    else if (ch == CH_WAVE) n = 3'd0;
    else n = 3'd1;
    return n;
  endfunction

  function automatic wr_t wr_decode(input logic [1:0] ch, input logic on,
                                    input logic [1:0] k, input logic [7:0] lo,
                                    input logic [2:0] fhi);
    wr_t w;
    logic [7:0] hi;
    logic [7:0] base;
    hi = D_TRIG | {5'd0, fhi & HI_MASK};
    w = '{addr: 8'h00, data: D_ZERO};
    case (ch)
      CH_PULSE1: base = 8'h11;
      CH_PULSE2: base = 8'h16;
      CH_WAVE:   base = 8'h20;
      default:   base = 8'h1B;
    endcase
    if (!on) begin
      case (ch)
        CH_PULSE1: w.addr = 8'h12;
        CH_PULSE2: w.addr = 8'h17;
        default:   w.addr = 8'h1C;
      endcase
      w.data = D_ZERO;
    end else begin
      case (ch)
        CH_PULSE1, CH_PULSE2: begin
          case (k)
            2'd0: w = '{addr: base + 8'd1, data: D_VOL_FULL};
            2'd1: w = '{addr: base,        data: D_DUTY};
            2'd2: w = '{addr: base + 8'd2, data: lo};
            default: w = '{addr: base + 8'd3, data: hi};
          endcase
        end
        CH_WAVE: begin
          case (k)
            2'd0: w = '{addr: base,        data: D_ZERO};
            2'd1: w = '{addr: base + 8'd1, data: D_WAVE_LEN};
            2'd2: w = '{addr: base + 8'd2, data: D_WAVE_LVL};
            default: w = '{addr: base + 8'd3, data: D_TRIG};
          endcase
        end
        default: begin
          case (k)
            2'd0: w = '{addr: base,        data: D_ZERO};
            2'd1: w = '{addr: base + 8'd1, data: D_NOISE};
            2'd2: w = '{addr: base + 8'd2, data: lo};
            default: w = '{addr: base + 8'd3, data: hi};
          endcase
        end
      endcase
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tes_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module tes_seq (
  input  wire              clk,
  input  wire              rst_n,
  input  tes_pkg::status_t status,
  output tes_pkg::act_t    act,
  output tes_pkg::step_t   step
);

  tes_pkg::step_t  step_r;
  tes_pkg::step_t  step_nxt;
  tes_pkg::cword_t cw;
  logic            take;

  assign cw   = tes_pkg::ucode(step_r);
  assign step = step_r;

  always_comb begin
    case (cw.cond)
      tes_pkg::COND_TICK_GO:    take = status.tick_go;
      tes_pkg::COND_RUN_OUT:    take = status.run_out;
      tes_pkg::COND_LATE:       take = status.late;
      tes_pkg::COND_EMIT_DONE:  take = status.emit_done;
      tes_pkg::COND_FLUSH_DONE: take = status.flush_done;
      default:                  take = 1'b1;
    endcase
    step_nxt = take ? cw.tgt_t : cw.tgt_f;
  end

  always_comb begin
    act = cw.act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= tes_pkg::STEP_IDLE;
    else step_r <= step_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/core/tes_datapath.sv
// Datapath: event store, counters, write decode, pending and output registers.
`default_nettype none
module tes_datapath #(
  parameter int EVENT_DEPTH     = 4096,
  parameter int EVENTS_PER_TICK = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  tes_pkg::act_t    act,
  input  tes_pkg::step_t   step,
  output tes_pkg::status_t status,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [1:0]       in_kind,
  input  wire  [11:0]      in_entry_index,
  input  wire  [15:0]      in_entry_frame,
  input  wire  [7:0]       in_entry_packed,
  input  wire  [7:0]       in_entry_freq_low,
  input  wire              in_pause_value,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [12:0]      cfg_data,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [7:0]       out_reg_addr,
  output logic [7:0]       out_reg_data,
  output logic [15:0]      out_tick_frame,
  output logic             out_last
);

  localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int NW = $clog2(EVENT_DEPTH + 1);
  localparam int UW = $clog2(EVENTS_PER_TICK + 1);

  logic [31:0]   mem [EVENT_DEPTH];
  logic [31:0]   rdata_r;
  logic [15:0]   frame_r;
  logic [15:0]   cur_f_r;
  logic [NW-1:0] next_r;
  logic [NW-1:0] limit_r;
  logic [NW-1:0] limit_nxt;
  logic [UW-1:0] used_r;
  logic [1:0]    k_r;
  logic          paused_r;
  logic [12:0]   count_r;
  logic          pend_v_r;
  tes_pkg::wr_t  pend_r;
  logic          out_v_r;
  tes_pkg::wr_t  out_r;
  logic [15:0]   out_f_r;
  logic          out_last_r;

  logic          in_fire;
  logic          tick_go;
  logic          load_ok;
  logic [1:0]    ch;
  logic          on;
  logic [2:0]    nwr;
  logic          k_end;
  logic          out_free;
  logic          can_emit;
  logic          do_emit;
  logic          consume;
  logic          do_flush;
  logic          push;
  logic          push_last;
  tes_pkg::wr_t  new_wr;

  assign in_stall  = !act.accept;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && act.accept;
  assign tick_go   = in_fire && (tes_pkg::kind_t'(in_kind) == tes_pkg::KIND_TICK) && !paused_r;
  assign load_ok   = in_fire && (tes_pkg::kind_t'(in_kind) == tes_pkg::KIND_LOAD)
                     && (32'(in_entry_index) < 32'(EVENT_DEPTH));
  assign limit_nxt = (32'(count_r) >= 32'(EVENT_DEPTH)) ? NW'(EVENT_DEPTH) : NW'(count_r);

  assign ch       = rdata_r[15:14];
  assign on       = rdata_r[13];
  assign nwr      = tes_pkg::wr_count(ch, on);
  assign new_wr   = tes_pkg::wr_decode(ch, on, k_r, rdata_r[7:0], rdata_r[10:8]);
  assign k_end    = ({1'b0, k_r} == (nwr - 3'd1));
  assign out_free = !out_v_r || !out_stall;
  assign can_emit = !pend_v_r || out_free;
  assign do_emit  = act.emit && (nwr != 3'd0) && can_emit;
  assign consume  = act.emit && ((nwr == 3'd0) || (can_emit && k_end));
  assign do_flush = act.flush && pend_v_r && out_free;
  assign push     = (do_emit && pend_v_r) || do_flush;
  assign push_last = do_flush;

  assign status.tick_go    = tick_go;
  assign status.run_out    = (used_r == UW'(EVENTS_PER_TICK)) || (next_r >= limit_r);
  assign status.late       = rdata_r[31:16] > cur_f_r;
  assign status.emit_done  = consume;
  assign status.flush_done = !pend_v_r || out_free;

  always_ff @(posedge clk) begin
    if (load_ok)
      mem[AW'(in_entry_index)] <= {in_entry_frame, in_entry_packed, in_entry_freq_low};
    if (act.read)
      rdata_r <= mem[next_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      next_r   <= '0;
      paused_r <= 1'b0;
      count_r  <= '0;
      used_r   <= '0;
      k_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid) count_r <= cfg_data;
      if (in_fire && (tes_pkg::kind_t'(in_kind) == tes_pkg::KIND_PAUSE))
        paused_r <= in_pause_value;
      if (in_fire && (tes_pkg::kind_t'(in_kind) == tes_pkg::KIND_RESTART)) begin
        frame_r <= '0;
        next_r  <= '0;
      end
      if (tick_go) begin
        cur_f_r <= frame_r;
        frame_r <= frame_r + 16'd1;
        used_r  <= '0;
        limit_r <= limit_nxt;
      end
      if (act.clear_k) k_r <= '0;
      if (do_emit) begin
        pend_r   <= new_wr;
        pend_v_r <= 1'b1;
      end
      if (consume) begin
        next_r <= next_r + NW'(1);
        used_r <= used_r + UW'(1);
        k_r    <= '0;
      end else if (do_emit) begin
        k_r <= k_r + 2'd1;
      end
      if (do_flush) pend_v_r <= 1'b0;
      if (push) begin
        out_v_r    <= 1'b1;
        out_r      <= pend_r;
        out_f_r    <= cur_f_r;
        out_last_r <= push_last;
      end else if (out_free) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_v_r;
  assign out_reg_addr   = out_r.addr;
  assign out_reg_data   = out_r.data;
  assign out_tick_frame = out_f_r;
  assign out_last       = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (step == tes_pkg::STEP_IDLE) |-> !pend_v_r)
    else $error("pending write left over at idle");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(EVENTS_PER_TICK))
    else $error("per-tick event count exceeded");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
    do_flush |=> (step == tes_pkg::STEP_IDLE))
    else $error("final write did not end the tick");

  a_emit_keeps_k: assert property (@(posedge clk) disable iff (!rst_n)
    (act.emit && !do_emit && (nwr != 3'd0)) |=> $stable(k_r))
    else $error("write index moved while output blocked");

endmodule
`default_nettype wire

// File: rtl/core/tick_event_sequencer.sv
// Top level of the tick event sequencer: sequencer plus datapath.
// Usage:
//   Load entries with kind=load items, set event_count through the cfg port,
//   then send one tick item per frame. Pause and restart items act at once.
//   Input channel: in_valid/in_stall; an item transfers when valid and not
//   stall. Output channel: out_valid/out_stall carries one register write per
//   transfer, out_last marks the final write of a tick.
//   Load, pause, restart and paused ticks are taken in the idle step and
//   start no scan. A running tick fetches each event from the store, ends
//   the scan on the per-tick event limit, the event_count limit or a late
//   entry, else emits the event's writes, if any, in turn, and closes with
//   a flush of the pending write. The control ROM walk and the event store
//   read order these steps. Each write waits in the pending register until
//   the next write or the flush pushes it into the output register.
//   in_stall stays high until the tick's last write has entered the output
//   register; a stalled receiver holds the output register and stops the
//   sequencer once one more write is pending.
//   Reset clears the frame counter, event pointer, pause flag and
//   event_count; the event store holds no defined content until loaded.
//   cfg_ready is always high; write cfg only while idle.
`default_nettype none
module tick_event_sequencer #(
  parameter int EVENT_DEPTH     = 4096,
  parameter int EVENTS_PER_TICK = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_kind,
  input  wire  [11:0] in_entry_index,
  input  wire  [15:0] in_entry_frame,
  input  wire  [7:0]  in_entry_packed,
  input  wire  [7:0]  in_entry_freq_low,
  input  wire         in_pause_value,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [12:0] cfg_data,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_reg_addr,
  output logic [7:0]  out_reg_data,
  output logic [15:0] out_tick_frame,
  output logic        out_last
);

  tes_pkg::status_t status;
  tes_pkg::act_t    act;
  tes_pkg::step_t   step;

  tes_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .act    (act),
    .step   (step)
  );

  tes_datapath #(
    .EVENT_DEPTH     (EVENT_DEPTH),
    .EVENTS_PER_TICK (EVENTS_PER_TICK)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .act               (act),
    .step              (step),
    .status            (status),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .in_entry_frame    (in_entry_frame),
    .in_entry_packed   (in_entry_packed),
    .in_entry_freq_low (in_entry_freq_low),
    .in_pause_value    (in_pause_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reg_addr      (out_reg_addr),
    .out_reg_data      (out_reg_data),
    .out_tick_frame    (out_tick_frame),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
